// File: design/ssbr_pkg.sv
// types, codes and arithmetic helpers shared by the root finder modules
package ssbr_pkg;

	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;

	localparam logic OP_START = 1'b0;
	localparam logic OP_REPLY = 1'b1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_END  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_END = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROOTS = 3'd4;

	typedef enum logic [1:0] {
		KIND_EVAL = 2'd0,
		KIND_ROOT = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_LEFT  = 2'd1,
		PH_RIGHT = 2'd2,
		PH_MID   = 2'd3
	} phase_t;

	typedef struct packed {
		logic               op;
		logic signed [31:0] fvalue;
	} in_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] point;
		logic [7:0]         root_index;
		logic               last;
	} out_t;

	typedef struct packed {
		logic signed [31:0] left_end;
		logic signed [31:0] right_end;
		logic [30:0]        scan_step;
		logic [30:0]        tolerance;
		logic [7:0]         max_roots;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic signed [31:0] left_point;
		logic signed [31:0] left_value;
		logic signed [31:0] right_point;
		logic signed [31:0] mid_point;
		logic [7:0]         found_count;
	} st_t;

	// a plus nonnegative b, clipped at the top of the signed range
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic [30:0] b);
		logic [32:0] s;
		s = {a[31], a} + {2'b00, b};
		if (!s[32] && s[31]) begin
			return Q_MAX;
		end
		return $signed(s[31:0]);
	endfunction

	function automatic out_t mk_res(input kind_t kind, input logic signed [31:0] point,
			input logic [7:0] idx, input logic last);
		out_t r;
		r.kind       = kind;
		r.point      = point;
		r.root_index = idx;
		r.last       = last;
		return r;
	endfunction

endpackage

// File: design/ssbr_next.sv
// next search state and results for one request, all combinational
module ssbr_next import ssbr_pkg::*; (
	input  in_t        item,
	input  st_t        st,
	input  cfg_t       cfg,
	output st_t        st_nxt,
	output out_t       res0,
	output out_t       res1,
	output logic [1:0] res_n
);

	logic signed [31:0] y;
	logic signed [31:0] hi, lo;
	logic [29:0]        half;
	logic signed [32:0] hi_h;
	logic [31:0]        y_abs;
	logic               val_small;
	logic               lv_pos, lv_neg, y_pos, y_neg;
	logic               same_sg, opp_sg;
	logic [7:0]         fc1;

	// bisection unit
	logic signed [31:0] bis_a, bis_b, bis_m;
	logic [32:0]        bis_s, bis_d, bis_w;
	logic               bis_close;

	// root report then rescan
	logic signed [31:0] small_pt, rs_base, rs_pt, rs_z;
	logic               go_z, go_rp, go_lo;

	// one step to the right
	logic signed [31:0] sr_base, sr_z;
	logic               sr_stuck;

	assign y    = item.fvalue;
	assign hi   = (cfg.left_end > cfg.right_end) ? cfg.left_end : cfg.right_end;
	assign lo   = (cfg.left_end < cfg.right_end) ? cfg.left_end : cfg.right_end;
	assign half = cfg.scan_step[30:1];
	assign hi_h = $signed({hi[31], hi} + {3'b000, half});

	assign y_abs     = y[31] ? (~y + 32'd1) : y;
	assign val_small = y_abs < {1'b0, cfg.tolerance};

	assign lv_pos  = !st.left_value[31] && (st.left_value != 32'sd0);
	assign lv_neg  = st.left_value[31];
	assign y_pos   = !y[31] && (y != 32'sd0);
	assign y_neg   = y[31];
	assign same_sg = (lv_pos && y_pos) || (lv_neg && y_neg);
	assign opp_sg  = (lv_pos && y_neg) || (lv_neg && y_pos);
	assign fc1     = st.found_count + 8'd1;

	// in the midpoint phase the midpoint replaces the end whose value has its sign
	assign bis_a = (st.phase == PH_MID && !opp_sg) ? st.mid_point : st.left_point;
	assign bis_b = (st.phase == PH_MID && opp_sg) ? st.mid_point : st.right_point;
	assign bis_s = {bis_a[31], bis_a} + {bis_b[31], bis_b};
	assign bis_m = $signed(bis_s[32:1]);
	assign bis_d = {bis_b[31], bis_b} - {bis_a[31], bis_a};
	assign bis_w = bis_d[32] ? (~bis_d + 33'd1) : bis_d;
	assign bis_close = (bis_w < {2'b00, cfg.tolerance}) || (bis_w <= 33'd1);

	always_comb begin
		unique case (st.phase)
			PH_LEFT:  small_pt = st.left_point;
			PH_RIGHT: small_pt = st.right_point;
			default:  small_pt = st.mid_point;
		endcase
	end

	assign rs_base = val_small ? small_pt : bis_b;
	assign rs_pt   = val_small ? small_pt : bis_m;
	assign rs_z    = sat_add(rs_base, {1'b0, half});
	assign go_z    = ($signed({rs_z[31], rs_z}) <= hi_h) && (fc1 != cfg.max_roots);
	assign go_rp   = ($signed({st.right_point[31], st.right_point}) <= hi_h) &&
		(st.found_count != cfg.max_roots);
	assign go_lo   = ($signed({lo[31], lo}) <= hi_h) && (cfg.max_roots != 8'd0);

	assign sr_base  = (st.phase == PH_RIGHT) ? st.right_point : st.left_point;
	assign sr_z     = sat_add(sr_base, cfg.scan_step);
	assign sr_stuck = sr_z == sr_base;

	always_comb begin
		logic do_root, do_step, do_bis, do_fin;
		do_root = 1'b0;
		do_step = 1'b0;
		do_bis  = 1'b0;
		do_fin  = 1'b0;
		st_nxt  = st;
		res0    = '0;
		res1    = '0;
		res_n   = 2'd0;

		if (item.op == OP_START) begin
			st_nxt.found_count = 8'd0;
			st_nxt.left_point  = lo;
			res_n = 2'd1;
			if (go_lo) begin
				st_nxt.phase = PH_LEFT;
				res0 = mk_res(KIND_EVAL, lo, 8'd0, 1'b1);
			end else begin
				st_nxt.phase = PH_IDLE;
				res0 = mk_res(KIND_DONE, 32'sd0, 8'd0, 1'b1);
			end
		end else begin
			unique case (st.phase)
				PH_IDLE: begin
				end
				PH_LEFT: begin
					st_nxt.left_value = y;
					if (val_small) begin
						do_root = 1'b1;
					end else begin
						do_step = 1'b1;
					end
				end
				PH_RIGHT: begin
					if (val_small) begin
						do_root = 1'b1;
					end else if (same_sg) begin
						st_nxt.left_point = st.right_point;
						st_nxt.left_value = y;
						if (go_rp) begin
							do_step = 1'b1;
						end else begin
							do_fin = 1'b1;
						end
					end else begin
						do_bis = 1'b1;
					end
				end
				PH_MID: begin
					if (val_small) begin
						do_root = 1'b1;
					end else begin
						if (opp_sg) begin
							st_nxt.right_point = st.mid_point;
						end else begin
							st_nxt.left_point = st.mid_point;
							st_nxt.left_value = y;
						end
						do_bis = 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (do_bis) begin
				if (bis_close) begin
					do_root = 1'b1;
				end else begin
					st_nxt.mid_point = bis_m;
					st_nxt.phase     = PH_MID;
					res0  = mk_res(KIND_EVAL, bis_m, st.found_count, 1'b1);
					res_n = 2'd1;
				end
			end

			if (do_step) begin
				res_n = 2'd1;
				if (sr_stuck) begin
					do_fin = 1'b1;
				end else begin
					st_nxt.right_point = sr_z;
					st_nxt.phase       = PH_RIGHT;
					res0 = mk_res(KIND_EVAL, sr_z, st.found_count, 1'b1);
				end
			end

			if (do_fin) begin
				st_nxt.phase = PH_IDLE;
				res0  = mk_res(KIND_DONE, 32'sd0, st.found_count, 1'b1);
				res_n = 2'd1;
			end

			if (do_root) begin
				st_nxt.found_count = fc1;
				st_nxt.left_point  = rs_z;
				res0  = mk_res(KIND_ROOT, rs_pt, fc1, 1'b0);
				res_n = 2'd2;
				if (go_z) begin
					st_nxt.phase = PH_LEFT;
					res1 = mk_res(KIND_EVAL, rs_z, fc1, 1'b1);
				end else begin
					st_nxt.phase = PH_IDLE;
					res1 = mk_res(KIND_DONE, 32'sd0, fc1, 1'b1);
				end
			end
		end
	end

endmodule

// File: design/ssbr_outq.sv
// four-entry result queue taking up to two results a cycle
module ssbr_outq import ssbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  out_t       push0,
	input  out_t       push1,
	output logic       room,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data
);

	out_t       ent_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign out_valid = cnt_q != 3'd0;
	assign out_data  = ent_q[rd_q];
	assign pop       = out_valid && !out_stall;
	// two free slots needed, since one request can yield two results
	assign room      = cnt_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			ent_q[wr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			ent_q[wr_q + 2'd1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

endmodule

// File: design/step_scan_bisection_root_finder_core.sv
// step scan and bisection root search sequencer, top level
// a request is registered, then processed into the result queue once the queue has room;
// its results then appear on out in order, each taken at an edge where out_stall is low
// throughput one request per cycle while the input does not stall; a request with two results
// shows them in turn; the input stalls only when the four-entry queue has fewer than two free slots
// reset clears the search state, empties the queue and loads the default register values
module step_scan_bisection_root_finder_core import ssbr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	in_t        item_s1;
	logic       item_vld_s1;
	st_t        st_q, st_nxt;
	cfg_t       cfg_q;
	out_t       res0, res1;
	logic [1:0] res_n;
	logic       room, proc;

	assign cfg_ready = 1'b1;
	assign proc      = item_vld_s1 && room;
	assign in_stall  = item_vld_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			item_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_end  <= 32'sd0;
			cfg_q.right_end <= 32'sd65536;
			cfg_q.scan_step <= 31'd6554;
			cfg_q.tolerance <= 31'd1;
			cfg_q.max_roots <= 8'd6;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LEFT_END:  cfg_q.left_end  <= $signed(cfg_data);
				CFG_RIGHT_END: cfg_q.right_end <= $signed(cfg_data);
				CFG_SCAN_STEP: cfg_q.scan_step <= cfg_data[30:0];
				CFG_TOLERANCE: cfg_q.tolerance <= cfg_data[30:0];
				CFG_MAX_ROOTS: cfg_q.max_roots <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, default: '0};
		end else if (proc) begin
			st_q <= st_nxt;
		end
	end

	ssbr_next u_next (
		.item   (item_s1),
		.st     (st_q),
		.cfg    (cfg_q),
		.st_nxt (st_nxt),
		.res0   (res0),
		.res1   (res1),
		.res_n  (res_n)
	);

	ssbr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (proc ? res_n : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: bench/testbench.sv
// self-checking testbench for the step scan bisection root finder core
module testbench;
	import ssbr_pkg::*;

	localparam longint Q_TOP = 64'sd2147483647;
	localparam longint Q_BOT = -64'sd2147483648;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 138;

	class root_search_board;
		longint end_a, end_b, step_w, tol_w;
		logic [7:0] root_cap;
		phase_t phase;
		longint lo_pt, lo_val, hi_pt, hi_val, mid_pt;
		logic [7:0] roots_seen;
		out_t awaited[$];
		out_t batch[$];
		int unsigned errors, checked, roots_reported;

		function new();
			end_a = 0;
			end_b = 65536;
			step_w = 6554;
			tol_w = 1;
			root_cap = 8'd6;
			phase = PH_IDLE;
			lo_pt = 0;
			lo_val = 0;
			hi_pt = 0;
			hi_val = 0;
			mid_pt = 0;
			roots_seen = 8'd0;
			errors = 0;
			checked = 0;
			roots_reported = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_LEFT_END: end_a = $signed(data);
				CFG_RIGHT_END: end_b = $signed(data);
				CFG_SCAN_STEP: step_w = data[30:0];
				CFG_TOLERANCE: tol_w = data[30:0];
				CFG_MAX_ROOTS: root_cap = data[7:0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v);
			if (v > Q_TOP) return Q_TOP;
			if (v < Q_BOT) return Q_BOT;
			return v;
		endfunction

		function bit tiny(longint v);
			longint mag;
			mag = (v < 0) ? -v : v;
			return mag < tol_w;
		endfunction

		function void emit(kind_t k, longint p);
			out_t r;
			r.kind = k;
			r.point = p[31:0];
			r.root_index = roots_seen;
			r.last = 1'b0;
			batch.push_back(r);
		endfunction

		function void close_search();
			phase = PH_IDLE;
			emit(KIND_DONE, 0);
		endfunction

		function bit scan_may_go();
			longint top;
			top = ((end_a > end_b) ? end_a : end_b) + (step_w >>> 1);
			return (lo_pt <= top) && (roots_seen != root_cap);
		endfunction

		function void report_root(longint p);
			roots_seen = roots_seen + 8'd1;
			roots_reported++;
			emit(KIND_ROOT, p);
		endfunction

		function void scan_from(longint z);
			lo_pt = z;
			if (!scan_may_go()) begin
				close_search();
				return;
			end
			phase = PH_LEFT;
			emit(KIND_EVAL, z);
		endfunction

		function void step_right();
			longint z1;
			z1 = clip(lo_pt + step_w);
			if (z1 == lo_pt) begin
				close_search();
				return;
			end
			hi_pt = z1;
			phase = PH_RIGHT;
			emit(KIND_EVAL, z1);
		endfunction

		function void bisect();
			longint w;
			w = hi_pt - lo_pt;
			if (w < 0) w = -w;
			// a bracket of one lsb cannot be split any further
			if (w < tol_w || w <= 1) begin
				report_root((lo_pt + hi_pt) >>> 1);
				scan_from(clip(hi_pt + (step_w >>> 1)));
				return;
			end
			mid_pt = (lo_pt + hi_pt) >>> 1;
			phase = PH_MID;
			emit(KIND_EVAL, mid_pt);
		endfunction

		function bit same_sign(longint a, longint b);
			return (a > 0 && b > 0) || (a < 0 && b < 0);
		endfunction

		function void note_request(in_t req);
			longint y;
			out_t tail;
			y = req.fvalue;
			batch.delete();
			if (req.op == OP_START) begin
				roots_seen = 8'd0;
				scan_from((end_a < end_b) ? end_a : end_b);
			end else begin
				case (phase)
					PH_LEFT: begin
						lo_val = y;
						if (tiny(y)) begin
							report_root(lo_pt);
							scan_from(clip(lo_pt + (step_w >>> 1)));
						end else begin
							step_right();
						end
					end
					PH_RIGHT: begin
						hi_val = y;
						if (tiny(y)) begin
							report_root(hi_pt);
							scan_from(clip(hi_pt + (step_w >>> 1)));
						end else if (same_sign(lo_val, y)) begin
							lo_pt = hi_pt;
							lo_val = y;
							if (!scan_may_go()) close_search();
							else step_right();
						end else begin
							bisect();
						end
					end
					PH_MID: begin
						if (tiny(y)) begin
							report_root(mid_pt);
							scan_from(clip(mid_pt + (step_w >>> 1)));
						end else if ((lo_val > 0 && y < 0) || (lo_val < 0 && y > 0)) begin
							hi_pt = mid_pt;
							hi_val = y;
							bisect();
						end else begin
							lo_pt = mid_pt;
							lo_val = y;
							bisect();
						end
					end
					default: ;
				endcase
			end
			if (batch.size() > 0) begin
				tail = batch.pop_back();
				tail.last = 1'b1;
				batch.push_back(tail);
			end
			foreach (batch[i]) awaited.push_back(batch[i]);
		endfunction

		function longint asked_point();
			case (phase)
				PH_LEFT: return lo_pt;
				PH_RIGHT: return hi_pt;
				PH_MID: return mid_pt;
				default: return 0;
			endcase
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing pending: kind %0d point %0d", got.kind, got.point);
				errors++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.kind !== want.kind) begin
				$error("kind expected %0d got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.point !== want.point) begin
				$error("point expected %0d got %0d", want.point, got.point);
				errors++;
			end
			if (got.root_index !== want.root_index) begin
				$error("root_index expected %0d got %0d", want.root_index, got.root_index);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0d got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	root_search_board board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int requests_sent = 0;
	int settings_used = 0;

	// synthetic function seen by the scan: sign flips at each root
	longint fn_roots[$];
	int fn_gain;
	bit fn_flip;
	longint fn_floor;

	step_scan_bisection_root_finder_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= arst_n && (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) board.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("step_scan_bisection_root_finder_core verification failed");
				$finish;
			end
		end
	end

	function automatic in_t req_of(logic op, logic signed [31:0] v);
		in_t r;
		r.op = op;
		r.fvalue = v;
		return r;
	endfunction

	function automatic void start_shape();
		longint lo, hi, span, pick;
		int n;
		lo = (board.end_a < board.end_b) ? board.end_a : board.end_b;
		hi = (board.end_a < board.end_b) ? board.end_b : board.end_a;
		span = hi - lo;
		fn_roots.delete();
		n = $urandom_range(0, 4);
		repeat (n) begin
			pick = $urandom;
			fn_roots.push_back(lo + pick % (span + 1));
		end
		fn_gain = $urandom_range(0, 3);
		fn_flip = $urandom_range(0, 1);
		fn_floor = $urandom_range(1, 1 << 20);
	endfunction

	function automatic logic signed [31:0] shape_value(longint x);
		longint gap_to_root, d;
		bit neg;
		int pick;
		pick = $urandom_range(99);
		if (pick < 12) return $urandom;
		if (pick < 18) return int'($urandom_range(0, 6)) - 3;
		neg = fn_flip;
		gap_to_root = fn_floor;
		foreach (fn_roots[i]) begin
			if (x > fn_roots[i]) neg = ~neg;
			d = x - fn_roots[i];
			if (d < 0) d = -d;
			if (i == 0 || d < gap_to_root) gap_to_root = d;
		end
		if (gap_to_root > (Q_TOP >>> fn_gain)) gap_to_root = Q_TOP;
		else gap_to_root = gap_to_root <<< fn_gain;
		return 32'(neg ? -gap_to_root : gap_to_root);
	endfunction

	task automatic push_request(in_t req);
		in_valid <= 1'b1;
		in_data <= req;
		do begin
			@(posedge clk);
		end while (in_stall);
		board.note_request(req);
		requests_sent++;
	endtask

	task automatic idle_gap();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (board.awaited.size() > 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[31:0];
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		board.write_reg(idx, v[31:0]);
	endtask

	task automatic apply_setting(int p);
		longint a, b, s, t, span;
		int m;
		case (p)
			0: begin a = 0; b = 65536; s = 6554; t = 1; m = 6; end
			// reversed ends, zero tolerance, widest root count
			1: begin a = 5 <<< 16; b = -(3 <<< 16); s = 1 << 14; t = 0; m = 255; end
			2: begin a = Q_BOT; b = Q_TOP; s = Q_TOP; t = Q_TOP; m = 255; end
			3: begin a = Q_TOP; b = Q_BOT; s = 1 << 28; t = 64; m = 3; end
			// scan runs into saturation at the top of the range
			4: begin a = Q_TOP - (3 <<< 16); b = Q_TOP; s = 1 << 15; t = 16; m = 8; end
			5: begin a = Q_BOT; b = Q_BOT + (2 <<< 16); s = 1; t = 1 << 10; m = 2; end
			6: begin a = -(1 <<< 16); b = 1 <<< 16; s = 4096; t = 4; m = 0; end
			default: begin
				a = $signed($urandom);
				b = $signed($urandom);
				span = (a > b) ? a - b : b - a;
				s = span / $urandom_range(4, 60);
				if (s < 1) s = 1;
				if (s > Q_TOP) s = Q_TOP;
				t = $urandom_range(0, 4096);
				m = $urandom_range(0, 255);
			end
		endcase
		write_reg(CFG_LEFT_END, a);
		write_reg(CFG_RIGHT_END, b);
		write_reg(CFG_SCAN_STEP, s);
		write_reg(CFG_TOLERANCE, t);
		write_reg(CFG_MAX_ROOTS, m);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic random_item(output bit counted);
		in_t req;
		int pick;
		pick = $urandom_range(99);
		counted = 1'b1;
		if (board.phase == PH_IDLE) begin
			if (pick < 8) begin
				// reply with no search running is dropped by the block
				req = req_of(OP_REPLY, $urandom);
				counted = 1'b0;
			end else begin
				start_shape();
				req = req_of(OP_START, $urandom);
			end
		end else if (pick < 4) begin
			start_shape();
			req = req_of(OP_START, $urandom);
		end else begin
			req = req_of(OP_REPLY, shape_value(board.asked_point()));
		end
		push_request(req);
	endtask

	task automatic directed_part();
		in_t seq[$];
		seq.push_back(req_of(OP_REPLY, 32'sh7fff_ffff));
		seq.push_back(req_of(OP_START, 32'sh0000_0000));
		seq.push_back(req_of(OP_REPLY, 32'sh8000_0000));
		seq.push_back(req_of(OP_REPLY, 32'sh7fff_ffff));
		seq.push_back(req_of(OP_REPLY, 32'sh0000_0000));
		seq.push_back(req_of(OP_REPLY, 32'sh0000_0001));
		seq.push_back(req_of(OP_REPLY, 32'sh0000_0001));
		seq.push_back(req_of(OP_REPLY, -32'sd1));
		seq.push_back(req_of(OP_REPLY, -32'sd5));
		seq.push_back(req_of(OP_REPLY, 32'sd7));
		seq.push_back(req_of(OP_REPLY, -32'sd3));
		seq.push_back(req_of(OP_REPLY, 32'sd2));
		seq.push_back(req_of(OP_START, 32'shffff_ffff));
		seq.push_back(req_of(OP_REPLY, 32'sh0000_0000));
		seq.push_back(req_of(OP_REPLY, 32'sh8000_0000));
		seq.push_back(req_of(OP_REPLY, 32'sh8000_0001));
		seq.push_back(req_of(OP_REPLY, 32'sh5555_5555));
		seq.push_back(req_of(OP_REPLY, 32'shaaaa_aaaa));
		seq.push_back(req_of(OP_REPLY, 32'sh0000_0000));
		seq.push_back(req_of(OP_START, 32'sh7fff_ffff));
		foreach (seq[i]) push_request(seq[i]);
	endtask

	initial begin
		int items;
		bit counted;
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		for (int p = 0; p < PHASES; p++) begin
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			apply_setting(p);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 52; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 52; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			items = 0;
			while (items < PHASE_ITEMS) begin
				idle_gap();
				random_item(counted);
				if (counted) begin
					items++;
					// hold the sender off until the block has emptied
					if (items == PHASE_ITEMS / 2) drain();
				end
			end
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d requests over %0d register settings, checked %0d results, %0d roots",
			requests_sent, settings_used, board.checked, board.roots_reported);
		$display("traffic ran free, with sender gaps, with output stalls and with both");
		if (board.errors == 0 && board.awaited.size() == 0) begin
			$display("step_scan_bisection_root_finder_core verification clean");
		end else begin
			$display("step_scan_bisection_root_finder_core verification failed");
		end
		$finish;
	end
endmodule
